### hw/rtl/mqui_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mqui_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MSG_BYTES   = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int DATA_W      = 64;
    localparam int LEN_W       = 4;
    localparam int SLOT_W      = DATA_W + LEN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Request codes
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_URGENT = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_READ_SMALL  = 3'd4;
    localparam logic [2:0] ST_WRITE_BIG   = 3'd5;
    localparam logic [2:0] ST_ZERO_SIZE   = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG = 2'd2;

    // Mask keeping the low n bytes of a message word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < n) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mqui_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface mqui_req_if;
    import mqui_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [DATA_W-1:0] msg_data;
    logic [LEN_W-1:0]  msg_len;
    modport source (output valid, req_type, msg_data, msg_len, input ready);
    modport sink   (input valid, req_type, msg_data, msg_len, output ready);
endinterface

// Response channel
interface mqui_rsp_if;
    import mqui_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  read_len;
    logic [CNT_W-1:0]  readable_count;
    logic [CNT_W-1:0]  writable_count;
    modport source (output valid, status, read_data, read_len, readable_count,
                    writable_count, input ready);
    modport sink   (input valid, status, read_data, read_len, readable_count,
                    writable_count, output ready);
endinterface

// Configuration write channel
interface mqui_cfg_if;
    import mqui_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mqui_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mqui_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/message_queue_with_urgent_insert.sv
`timescale 1ns / 1ps
`default_nettype none

// Message queue with urgent insert: a ring of message slots held in one
// synchronous RAM (68 bits per slot: 64 data bits and a 4-bit length).
// Channels: req (read at head, write at tail, urgent write at head), rsp
// (one response per request, with status and both counts), cfg (register
// writes; any write to a known register empties the queue).
// Timing: a write or a failed request is answered in the response register
// at the transfer edge itself; a successful read goes through the registered
// RAM read port, so its response is loaded in the cycle after the transfer.
// Throughput: one request per cycle for writes and failures while responses
// are taken; a successful read blocks requests until its response loads.
// A new request is taken while the previous response is being transferred.
// Reset: queue enabled, length 16, maximum message 8 bytes, queue empty; the
// slot RAM is not cleared, since a slot is only read after it was written.
// Receiver stall: the response is held in its register and req.ready stays
// low until it is transferred; cfg.ready is always high.
module message_queue_with_urgent_insert (
    input  wire logic clk,
    input  wire logic rst_n,
    mqui_req_if.sink  req,
    mqui_rsp_if.source rsp,
    mqui_cfg_if.sink  cfg
);
    import mqui_pkg::*;

    typedef enum logic {S_IDLE, S_READ} state_t;

    state_t               state_reg;
    logic                 enabled_reg;
    logic [CNT_W-1:0]     length_reg;
    logic [LEN_W-1:0]     max_msg_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     tail_reg;
    logic [CNT_W-1:0]     held_reg;
    logic [CNT_W-1:0]     free_reg;

    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [CNT_W-1:0]     out_held_reg;
    logic [CNT_W-1:0]     out_free_reg;

    logic                 req_xfer;
    logic                 cfg_xfer;
    logic                 rsp_load;
    logic [CNT_W-1:0]     eff_len;
    logic [LEN_W-1:0]     eff_max;
    logic [2:0]           status_c;
    logic                 do_read;
    logic                 do_write;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_next;
    logic [CNT_W-1:0]     held_next;
    logic [CNT_W-1:0]     free_next;
    logic [IDX_W-1:0]     wr_pos;
    logic [CNT_W-1:0]     head_inc;
    logic [CNT_W-1:0]     tail_inc;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wdata;
    logic [SLOT_W-1:0]    mem_rdata;
    logic [CNT_W-1:0]     cfg_len_new;

    // Clamp a queue length to the range of the RAM
    function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] ql);
        if (ql == '0)
        begin
            return CNT_W'(1);
        end
        else if (ql > CNT_W'(QUEUE_DEPTH))
        begin
            return CNT_W'(QUEUE_DEPTH);
        end
        return ql;
    endfunction

    assign req_xfer  = req.valid && req.ready;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;

    // A new response enters the output register this cycle
    assign rsp_load = (state_reg == S_READ) || (state_reg == S_IDLE && req_xfer && !do_read);

    assign eff_len = clamp_len(length_reg);
    assign eff_max = (max_msg_reg > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : max_msg_reg;

    // Check the request in priority order
    always_comb
    begin
        status_c = ST_OK;
        do_read  = 1'b0;
        do_write = 1'b0;
        if (req.req_type == REQ_NONE)
        begin
            status_c = ST_OK;
        end
        else if (req.msg_len == '0)
        begin
            status_c = ST_ZERO_SIZE;
        end
        else if (!enabled_reg)
        begin
            status_c = ST_NOT_ENABLED;
        end
        else if (req.req_type == REQ_READ && req.msg_len < eff_max)
        begin
            status_c = ST_READ_SMALL;
        end
        else if (req.req_type != REQ_READ && req.msg_len > eff_max)
        begin
            status_c = ST_WRITE_BIG;
        end
        else if (req.req_type == REQ_READ && held_reg == '0)
        begin
            status_c = ST_EMPTY;
        end
        else if (req.req_type != REQ_READ && free_reg == '0)
        begin
            status_c = ST_FULL;
        end
        else if (req.req_type == REQ_READ)
        begin
            do_read = 1'b1;
        end
        else
        begin
            do_write = 1'b1;
        end
    end

    // Advance pointers and counts
    always_comb
    begin
        head_inc  = CNT_W'(head_reg) + CNT_W'(1);
        tail_inc  = CNT_W'(tail_reg) + CNT_W'(1);
        head_next = head_reg;
        tail_next = tail_reg;
        held_next = held_reg;
        free_next = free_reg;
        wr_pos    = tail_reg;
        if (do_read)
        begin
            head_next = (head_inc >= eff_len) ? '0 : head_inc[IDX_W-1:0];
            held_next = held_reg - CNT_W'(1);
            free_next = free_reg + CNT_W'(1);
        end
        else if (do_write)
        begin
            if (req.req_type == REQ_WRITE)
            begin
                tail_next = (tail_inc >= eff_len) ? '0 : tail_inc[IDX_W-1:0];
                wr_pos    = tail_reg;
            end
            else
            begin
                if (head_reg == '0 || CNT_W'(head_reg) >= eff_len)
                begin
                    head_next = IDX_W'(eff_len - CNT_W'(1));
                end
                else
                begin
                    head_next = head_reg - IDX_W'(1);
                end
                wr_pos = head_next;
            end
            held_next = held_reg + CNT_W'(1);
            free_next = free_reg - CNT_W'(1);
        end
    end

    assign mem_we    = req_xfer && do_write;
    assign mem_wdata = {req.msg_len, req.msg_data & byte_mask(req.msg_len)};

    assign cfg_len_new = (cfg.index == CFG_LENGTH) ? clamp_len(cfg.data) : eff_len;

    mqui_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_pos),
        .wdata (mem_wdata),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    // Hold queue state, sequence reads and register the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enabled_reg    <= 1'b1;
            length_reg     <= CNT_W'(QUEUE_DEPTH);
            max_msg_reg    <= LEN_W'(MSG_BYTES);
            head_reg       <= '0;
            tail_reg       <= '0;
            held_reg       <= '0;
            free_reg       <= CNT_W'(QUEUE_DEPTH);
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_data_reg   <= '0;
            out_len_reg    <= '0;
            out_held_reg   <= '0;
            out_free_reg   <= '0;
        end
        else
        begin
            // Drop the transferred response unless a new one loads
            if (rsp.valid && rsp.ready && !rsp_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        head_reg <= head_next;
                        tail_reg <= tail_next;
                        held_reg <= held_next;
                        free_reg <= free_next;
                        if (do_read)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= status_c;
                            out_data_reg   <= '0;
                            out_len_reg    <= '0;
                            out_held_reg   <= held_next;
                            out_free_reg   <= free_next;
                        end
                    end
                end
                S_READ:
                begin
                    // Slot arrives from the RAM read register
                    state_reg      <= S_IDLE;
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= ST_OK;
                    out_data_reg   <= mem_rdata[DATA_W-1:0];
                    out_len_reg    <= mem_rdata[SLOT_W-1:DATA_W];
                    out_held_reg   <= held_reg;
                    out_free_reg   <= free_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Apply a register write and empty the queue
            if (cfg_xfer && (cfg.index == CFG_ENABLED || cfg.index == CFG_LENGTH ||
                             cfg.index == CFG_MAX_MSG))
            begin
                case (cfg.index)
                    CFG_ENABLED: enabled_reg <= cfg.data[0];
                    CFG_LENGTH:  length_reg  <= cfg.data;
                    CFG_MAX_MSG: max_msg_reg <= cfg.data[LEN_W-1:0];
                    default:     enabled_reg <= enabled_reg;
                endcase
                head_reg <= '0;
                tail_reg <= '0;
                held_reg <= '0;
                free_reg <= cfg_len_new;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.read_len       = out_len_reg;
    assign rsp.readable_count = out_held_reg;
    assign rsp.writable_count = out_free_reg;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mqui_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;
    localparam int TAIL_CYCLES = 8;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [1:0]        kind;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } mq_request_t;

    typedef struct {
        logic [2:0]        status;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  held;
        logic [CNT_W-1:0]  free;
    } mq_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    mqui_req_if req_ch ();
    mqui_rsp_if rsp_ch ();
    mqui_cfg_if cfg_ch ();

    message_queue_with_urgent_insert u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the queue: registers, slots, pointers and counts
    logic              sh_enabled;
    logic [4:0]        sh_length;
    logic [3:0]        sh_max;
    logic [DATA_W-1:0] slot_word [QUEUE_DEPTH];
    logic [LEN_W-1:0]  slot_len  [QUEUE_DEPTH];
    int unsigned       head_q;
    int unsigned       tail_q;
    int unsigned       held_q;
    int unsigned       free_q;

    mq_request_t pending_q [$];
    mq_reply_t   awaited_q [$];

    bit idle_on = 1'b1;
    int send_gap;
    int stall_left;
    int hold_left;
    int hold_asked;
    int hold_seen;
    int accepted_cnt;
    int checked_cnt;
    int error_cnt;
    int reg_write_cnt;
    int settings_cnt;
    int cycle_cnt;
    int status_seen [8];

    // Wrap point of the ring, clamped into 1..QUEUE_DEPTH
    function automatic int unsigned ring_size();
        if (sh_length == 0)
            return 1;
        if (sh_length > QUEUE_DEPTH)
            return QUEUE_DEPTH;
        return sh_length;
    endfunction

    // Largest accepted message, clamped to the slot size
    function automatic int unsigned size_cap();
        return (sh_max > MSG_BYTES) ? MSG_BYTES : sh_max;
    endfunction

    function automatic logic [DATA_W-1:0] low_bytes(int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void clear_ring();
        head_q = 0;
        tail_q = 0;
        held_q = 0;
        free_q = ring_size();
    endfunction

    // Register write; an unknown index leaves the queue alone
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ENABLED: sh_enabled = value[0];
            CFG_LENGTH:  sh_length  = value;
            CFG_MAX_MSG: sh_max     = value[3:0];
            default:     return;
        endcase
        clear_ring();
    endfunction

    // Serve one request against the shadow queue and return its reply
    function automatic mq_reply_t serve_request(mq_request_t rq);
        mq_reply_t   r;
        int unsigned lim;
        int unsigned cap;
        int unsigned pos;
        lim      = ring_size();
        cap      = size_cap();
        r.status = ST_OK;
        r.data   = '0;
        r.len    = '0;
        if (rq.kind == REQ_NONE)
            r.status = ST_OK;
        else if (rq.len == 0)
            r.status = ST_ZERO_SIZE;
        else if (!sh_enabled)
            r.status = ST_NOT_ENABLED;
        else if (rq.kind == REQ_READ && rq.len < cap)
            r.status = ST_READ_SMALL;
        else if (rq.kind != REQ_READ && rq.len > cap)
            r.status = ST_WRITE_BIG;
        else if (rq.kind == REQ_READ && held_q == 0)
            r.status = ST_EMPTY;
        else if (rq.kind != REQ_READ && free_q == 0)
            r.status = ST_FULL;
        else if (rq.kind == REQ_READ)
        begin
            // take from the head
            pos    = head_q;
            head_q = (head_q + 1 >= lim) ? 0 : head_q + 1;
            r.len  = slot_len[pos];
            r.data = slot_word[pos] & low_bytes(slot_len[pos]);
            held_q--;
            free_q++;
        end
        else
        begin
            // normal send at the tail, urgent send one step before the head
            if (rq.kind == REQ_WRITE)
            begin
                pos    = tail_q;
                tail_q = (tail_q + 1 >= lim) ? 0 : tail_q + 1;
            end
            else
            begin
                head_q = (head_q == 0 || head_q >= lim) ? lim - 1 : head_q - 1;
                pos    = head_q;
            end
            slot_word[pos] = rq.data & low_bytes(rq.len);
            slot_len[pos]  = rq.len;
            free_q--;
            held_q++;
        end
        r.held = held_q[CNT_W-1:0];
        r.free = free_q[CNT_W-1:0];
        return r;
    endfunction

    // Random request: mostly well-formed sends and reads, some noise
    function automatic mq_request_t make_random_item(int write_pct);
        mq_request_t rq;
        int unsigned cap;
        int unsigned roll;
        cap     = size_cap();
        roll    = $urandom_range(0, 99);
        rq.data = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       rq.data = '1;
            1:       rq.data = '0;
            default: ;
        endcase
        if (roll < 8)
        begin
            rq.kind = 2'($urandom_range(0, 3));
            rq.len  = 4'($urandom_range(0, 15));
        end
        else if (roll < 8 + write_pct)
        begin
            rq.kind = ($urandom_range(0, 3) == 0) ? REQ_URGENT : REQ_WRITE;
            rq.len  = (cap == 0) ? 4'($urandom_range(1, 15)) : 4'($urandom_range(1, cap));
        end
        else
        begin
            rq.kind = REQ_READ;
            rq.len  = 4'($urandom_range((cap == 0) ? 1 : cap, 15));
        end
        return rq;
    endfunction

    task automatic report_mismatch(string what);
        error_cnt++;
        if (error_cnt <= PRINT_LIMIT)
            $display("MISMATCH at reply %0d: %s", checked_cnt, what);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic push_item(logic [1:0] kind, logic [DATA_W-1:0] data, logic [LEN_W-1:0] len);
        mq_request_t rq;
        rq.kind = kind;
        rq.data = data;
        rq.len  = len;
        pending_q.push_back(rq);
    endtask

    // Hold until every queued item has moved and every reply has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || awaited_q.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, value);
        reg_write_cnt++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Program all three registers, with junk in the unused upper bits
    task automatic set_queue(bit en, logic [4:0] length, logic [3:0] max_bytes);
        wait_drained();
        write_register(CFG_ENABLED, {4'($urandom_range(0, 15)), en});
        write_register(CFG_LENGTH, length);
        write_register(CFG_MAX_MSG, {1'($urandom_range(0, 1)), max_bytes});
        if ($urandom_range(0, 1) == 1)
            write_register(CFG_SPARE, 5'($urandom));
        settings_cnt++;
        @(negedge clk);
    endtask

    task automatic run_phase(bit en, logic [4:0] length, logic [3:0] max_bytes, int count,
                             bit long_hold, bit pause_mid);
        int write_pct;
        write_pct = 45;
        set_queue(en, length, max_bytes);
        if (long_hold)
            hold_asked++;
        for (int i = 0; i < count; i++)
        begin
            // swing between filling and draining so both ends are reached
            if (i % 24 == 0)
                write_pct = 20 + 25 * $urandom_range(0, 2);
            if (pause_mid && i == count / 2)
            begin
                wait_drained();
                repeat ($urandom_range(5, 40)) @(negedge clk);
            end
            pending_q.push_back(make_random_item(write_pct));
        end
        wait_drained();
    endtask

    // Request driver: predict on each transfer, then offer the next item
    always @(posedge clk)
    begin : drive_req
        mq_request_t rq;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                rq.kind = req_ch.req_type;
                rq.data = req_ch.msg_data;
                rq.len  = req_ch.msg_len;
                awaited_q.push_back(serve_request(rq));
                accepted_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    rq = pending_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= rq.kind;
                    req_ch.msg_data <= rq.data;
                    req_ch.msg_len  <= rq.len;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Reply monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin : watch_rsp
        mq_reply_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                checked_cnt++;
                status_seen[rsp_ch.status]++;
                if (awaited_q.size() == 0)
                    report_mismatch($sformatf("reply with status %0d and nothing outstanding",
                                              rsp_ch.status));
                else
                begin
                    want = awaited_q.pop_front();
                    check_field("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
                    check_field("read_data", rsp_ch.read_data, want.data);
                    check_field("read_len", DATA_W'(rsp_ch.read_len), DATA_W'(want.len));
                    check_field("readable_count", DATA_W'(rsp_ch.readable_count),
                                DATA_W'(want.held));
                    check_field("writable_count", DATA_W'(rsp_ch.writable_count),
                                DATA_W'(want.free));
                end
            end
            // back-pressure: long hold on request, else random stall bursts
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, awaited_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_NONE;
        req_ch.msg_data = '0;
        req_ch.msg_len  = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_ENABLED;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        sh_enabled      = 1'b1;
        sh_length       = 5'd16;
        sh_max          = 4'd8;
        clear_ring();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Error ordering and size limits at reset settings
        push_item(REQ_READ, '0, 4'd8);
        push_item(REQ_READ, '0, 4'd0);
        push_item(REQ_WRITE, '1, 4'd0);
        push_item(REQ_READ, '0, 4'd7);
        push_item(REQ_WRITE, '1, 4'd9);
        push_item(REQ_URGENT, '1, 4'd15);
        push_item(REQ_WRITE, '1, 4'd8);
        push_item(REQ_WRITE, 64'h0123_4567_89ab_cdef, 4'd1);
        push_item(REQ_URGENT, '1, 4'd3);
        push_item(REQ_NONE, '1, 4'd15);
        wait_drained();
        // unknown register index must not empty the queue
        write_register(CFG_SPARE, '1);
        @(negedge clk);
        push_item(REQ_READ, '0, 4'd15);
        push_item(REQ_READ, '0, 4'd15);
        push_item(REQ_READ, '0, 4'd8);
        push_item(REQ_READ, '0, 4'd8);

        // Zero length acts as a single slot
        set_queue(1'b1, 5'd0, 4'd8);
        push_item(REQ_WRITE, '1, 4'd8);
        push_item(REQ_WRITE, '1, 4'd2);
        push_item(REQ_URGENT, '1, 4'd2);
        push_item(REQ_READ, '0, 4'd8);
        push_item(REQ_READ, '0, 4'd8);

        // Zero maximum size: every write too big, read needs a non-zero buffer
        set_queue(1'b1, 5'd16, 4'd0);
        push_item(REQ_WRITE, '1, 4'd1);
        push_item(REQ_READ, '0, 4'd1);
        push_item(REQ_READ, '0, 4'd0);

        // Disabled queue; zero size is still checked first
        set_queue(1'b0, 5'd16, 4'd8);
        push_item(REQ_READ, '0, 4'd8);
        push_item(REQ_URGENT, '1, 4'd1);
        push_item(REQ_WRITE, '1, 4'd0);

        // Random phases across the register space
        run_phase(1'b1, 5'd16, 4'd8, 170, 1'b0, 1'b1);
        run_phase(1'b1, 5'd1, 4'd1, 170, 1'b0, 1'b0);
        run_phase(1'b1, 5'd31, 4'd15, 170, 1'b1, 1'b0);
        run_phase(1'b1, 5'd3, 4'd4, 170, 1'b0, 1'b1);
        run_phase(1'b1, 5'd0, 4'd0, 170, 1'b0, 1'b0);
        run_phase(1'b0, 5'd8, 4'd8, 170, 1'b0, 1'b0);
        run_phase(1'b1, 5'd16, 4'd1, 170, 1'b0, 1'b1);
        run_phase(1'b1, 5'($urandom_range(1, 16)), 4'($urandom_range(1, 8)), 170,
                  1'b0, 1'b0);
        run_phase(1'b1, 5'd7, 4'd8, 170, 1'b1, 1'b0);

        // Closing phase at full rate on both sides
        idle_on = 1'b0;
        run_phase(1'b1, 5'd16, 4'd8, 170, 1'b0, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d requests and %0d replies over %0d settings",
                 accepted_cnt, checked_cnt, settings_cnt);
        $display("  (%0d register writes); replies: ok %0d, disabled %0d, empty %0d,",
                 reg_write_cnt, status_seen[ST_OK], status_seen[ST_NOT_ENABLED],
                 status_seen[ST_EMPTY]);
        $display("  full %0d, small read %0d, big write %0d, zero %0d",
                 status_seen[ST_FULL], status_seen[ST_READ_SMALL], status_seen[ST_WRITE_BIG],
                 status_seen[ST_ZERO_SIZE]);
        if (error_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
